/* hdl/rbps_pkg.sv */
// rbps_pkg: shared types and constants of the best-path selector
// beat payload structs for the input and result channels, queue entry type
// no dependencies
package rbps_pkg;

  localparam int unsigned LP_W   = 32;
  localparam int unsigned HOPS_W = 8;
  localparam int unsigned ORG_W  = 2;
  localparam int unsigned MED_W  = 32;
  localparam int unsigned TIME_W = 64;
  localparam int unsigned IDX_W  = 8;

  localparam logic [LP_W-1:0] DEFAULT_LP_RESET = 32'd100;

  localparam int unsigned QDEPTH = 4;
  localparam int unsigned QAW    = $clog2(QDEPTH);
  localparam int unsigned QCW    = $clog2(QDEPTH + 1);

  typedef struct packed {
    logic              route_valid;
    logic              via_tunnel;
    logic              carries_lp;
    logic [LP_W-1:0]   lp_value;
    logic [HOPS_W-1:0] as_hops;
    logic [ORG_W-1:0]  origin;
    logic              has_med;
    logic [MED_W-1:0]  med;
    logic              prefix_is_ip;
    logic              nexthop_same_family;
    logic [TIME_W-1:0] updated_time;
    logic              last;
  } route_in_t;

  typedef struct packed {
    logic             best_found;
    logic [IDX_W-1:0] best_index;
  } route_out_t;

  // classified candidate as held in the queue
  typedef struct packed {
    logic              consider;
    logic              via_tunnel;
    logic [LP_W-1:0]   pref;
    logic [HOPS_W-1:0] as_hops;
    logic [ORG_W-1:0]  origin;
    logic              has_med;
    logic [MED_W-1:0]  med;
    logic              prefix_is_ip;
    logic              same_family;
    logic [TIME_W-1:0] updated_time;
    logic [IDX_W-1:0]  position;
    logic              last;
  } route_job_t;

endpackage

/* hdl/route_best_path_select.sv */
// route_best_path_select: top level of the per-prefix best-path selector
// front classifier, candidate queue and comparison back end; depends on rbps_pkg
//
//   channel  | direction | handshake            | beat
//   ---------+-----------+----------------------+---------------------------
//   in_      | input     | in_valid / in_stall  | route_in_t candidate
//   out_     | output    | out_valid / out_stall| route_out_t best path
//   cfg_     | input     | cfg_valid / cfg_ready| default local preference
//
// one candidate beat per cycle while in_stall is low; the comparison chain in the back end decides
// the result, which is registered once the last beat has left the queue and the output register is free
// a four-entry queue absorbs output stalls; in_stall rises when it is full
// synchronous reset empties the queue, clears the best route and position counter,
// and sets the default local preference to 100
module route_best_path_select #(
  parameter int unsigned MAX_ROUTES = 256
) (
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic                      in_valid,
  output logic                      in_stall,
  input  rbps_pkg::route_in_t       in_data,
  output logic                      out_valid,
  input  logic                      out_stall,
  output rbps_pkg::route_out_t      out_data,
  input  logic                      cfg_valid,
  output logic                      cfg_ready,
  input  logic [rbps_pkg::LP_W-1:0] cfg_data
);

  logic                 q_full;
  logic                 q_empty;
  logic                 q_push;
  logic                 q_pop;
  rbps_pkg::route_job_t push_job;
  rbps_pkg::route_job_t head_job;

  rbps_front #(
    .MAX_ROUTES(MAX_ROUTES)
  ) u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_data   (in_data),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_data  (cfg_data),
    .q_full    (q_full),
    .q_push    (q_push),
    .q_job     (push_job)
  );

  rbps_queue u_queue (
    .clk      (clk),
    .rst_n    (rst_n),
    .push     (q_push),
    .push_job (push_job),
    .full     (q_full),
    .pop      (q_pop),
    .empty    (q_empty),
    .head_job (head_job)
  );

  rbps_back u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .q_empty   (q_empty),
    .q_job     (head_job),
    .q_pop     (q_pop),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data)
  );

endmodule

/* hdl/rbps_front.sv */
// rbps_front: accepts candidate beats, resolves local preference and position
// holds the default local preference register and the position counter
// depends on rbps_pkg
module rbps_front #(
  parameter int unsigned MAX_ROUTES = 256
) (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       in_valid,
  output logic                       in_stall,
  input  rbps_pkg::route_in_t        in_data,
  input  logic                       cfg_valid,
  output logic                       cfg_ready,
  input  logic [rbps_pkg::LP_W-1:0]  cfg_data,
  input  logic                       q_full,
  output logic                       q_push,
  output rbps_pkg::route_job_t       q_job
);

  localparam int unsigned PW = $clog2(MAX_ROUTES + 1);

  logic [rbps_pkg::LP_W-1:0] default_lp_r;
  logic [PW-1:0]             pos_r;
  logic [PW-1:0]             pos_nxt;
  logic [PW+rbps_pkg::IDX_W-1:0] pos_ext;
  logic                      in_range;

  assign cfg_ready = 1'b1;
  assign in_stall  = q_full;
  assign q_push    = in_valid && !q_full;

  assign in_range = pos_r < PW'(MAX_ROUTES);
  assign pos_ext  = {{rbps_pkg::IDX_W{1'b0}}, pos_r};

  always_comb begin
    q_job.consider     = in_data.route_valid && in_range;
    q_job.via_tunnel   = in_data.via_tunnel;
    q_job.pref         = in_data.carries_lp ? in_data.lp_value : default_lp_r;
    q_job.as_hops      = in_data.as_hops;
    q_job.origin       = in_data.origin;
    q_job.has_med      = in_data.has_med;
    q_job.med          = in_data.med;
    q_job.prefix_is_ip = in_data.prefix_is_ip;
    q_job.same_family  = in_data.nexthop_same_family;
    q_job.updated_time = in_data.updated_time;
    q_job.position     = pos_ext[rbps_pkg::IDX_W-1:0];
    q_job.last         = in_data.last;
  end

  always_comb begin
    pos_nxt = pos_r;
    if (q_push) begin
      if (in_data.last) begin
        pos_nxt = '0;
      end else if (in_range) begin
        pos_nxt = pos_r + PW'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      default_lp_r <= rbps_pkg::DEFAULT_LP_RESET;
      pos_r        <= '0;
    end else begin
      if (cfg_valid && cfg_ready) begin
        default_lp_r <= cfg_data;
      end
      pos_r <= pos_nxt;
    end
  end

endmodule

/* hdl/rbps_queue.sv */
// rbps_queue: short fifo of classified candidates between front and back
// depends on rbps_pkg
module rbps_queue (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 push,
  input  rbps_pkg::route_job_t push_job,
  output logic                 full,
  input  logic                 pop,
  output logic                 empty,
  output rbps_pkg::route_job_t head_job
);

  rbps_pkg::route_job_t mem [rbps_pkg::QDEPTH];

  logic [rbps_pkg::QAW-1:0] wr_ptr_r;
  logic [rbps_pkg::QAW-1:0] rd_ptr_r;
  logic [rbps_pkg::QCW-1:0] count_r;
  logic [rbps_pkg::QCW-1:0] count_nxt;

  assign full     = count_r == rbps_pkg::QCW'(rbps_pkg::QDEPTH);
  assign empty    = count_r == '0;
  assign head_job = mem[rd_ptr_r];

  always_comb begin
    count_nxt = count_r;
    if (push && !pop) begin
      count_nxt = count_r + rbps_pkg::QCW'(1);
    end else if (pop && !push) begin
      count_nxt = count_r - rbps_pkg::QCW'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      mem[wr_ptr_r] <= push_job;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      if (push) begin
        wr_ptr_r <= wr_ptr_r + rbps_pkg::QAW'(1);
      end
      if (pop) begin
        rd_ptr_r <= rd_ptr_r + rbps_pkg::QAW'(1);
      end
      count_r <= count_nxt;
    end
  end

endmodule

/* hdl/rbps_back.sv */
// rbps_back: compares each queued candidate against the held best route
// emits the result beat on the last candidate of a prefix; depends on rbps_pkg
module rbps_back (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 q_empty,
  input  rbps_pkg::route_job_t q_job,
  output logic                 q_pop,
  output logic                 out_valid,
  input  logic                 out_stall,
  output rbps_pkg::route_out_t out_data
);

  rbps_pkg::route_job_t best_r;
  logic                 have_best_r;
  logic                 out_valid_r;
  logic                 out_valid_nxt;
  rbps_pkg::route_out_t out_data_r;
  rbps_pkg::route_out_t out_data_nxt;
  logic                 beats;
  logic                 win;

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  assign q_pop = !q_empty && (!q_job.last || !out_valid_r || !out_stall);

  // preference chain, first differing criterion that applies decides
  always_comb begin
    beats = 1'b0;
    if (!have_best_r) begin
      beats = 1'b1;
    end else if (q_job.via_tunnel != best_r.via_tunnel) begin
      beats = !q_job.via_tunnel;
    end else if (q_job.pref != best_r.pref) begin
      beats = q_job.pref > best_r.pref;
    end else if (q_job.as_hops != best_r.as_hops) begin
      beats = q_job.as_hops < best_r.as_hops;
    end else if (q_job.origin != best_r.origin) begin
      beats = q_job.origin < best_r.origin;
    end else if (q_job.has_med && best_r.has_med && q_job.med != best_r.med) begin
      beats = q_job.med < best_r.med;
    end else if (q_job.prefix_is_ip && q_job.same_family != best_r.same_family) begin
      beats = q_job.same_family;
    end else begin
      beats = q_job.updated_time > best_r.updated_time;
    end
  end

  assign win = q_pop && q_job.consider && beats;

  always_comb begin
    out_data_nxt.best_found = have_best_r || win;
    if (win) begin
      out_data_nxt.best_index = q_job.position;
    end else if (have_best_r) begin
      out_data_nxt.best_index = best_r.position;
    end else begin
      out_data_nxt.best_index = '0;
    end
  end

  always_comb begin
    out_valid_nxt = out_valid_r;
    if (q_pop && q_job.last) begin
      out_valid_nxt = 1'b1;
    end else if (out_valid_r && !out_stall) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (win) begin
      best_r <= q_job;
    end
    if (q_pop && q_job.last) begin
      out_data_r <= out_data_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      have_best_r <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      if (q_pop && q_job.last) begin
        have_best_r <= 1'b0;
      end else if (win) begin
        have_best_r <= 1'b1;
      end
      out_valid_r <= out_valid_nxt;
    end
  end

endmodule

/* hdl/rbps_checker.sv */
// rbps_checker: port-level checks of the best-path selector
// bound to route_best_path_select; depends on rbps_pkg
module rbps_checker (
  input logic                 clk,
  input logic                 rst_n,
  input logic                 in_valid,
  input logic                 in_stall,
  input logic                 out_valid,
  input logic                 out_stall,
  input rbps_pkg::route_out_t out_data,
  input logic                 cfg_ready
);

  // stalled result beat holds
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_data))
    else $error("result beat changed under stall");

  // withdraw carries index zero
  a_withdraw_idx: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_data.best_found |-> out_data.best_index == '0)
    else $error("withdraw with nonzero index");

  // reset leaves no result and an open input
  a_reset_state: assert property (@(posedge clk)
    !rst_n |=> !out_valid && !in_stall)
    else $error("state not cleared by reset");

  // config port never blocks
  a_cfg_ready: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid || !in_valid |-> cfg_ready)
    else $error("config port not ready");

endmodule

bind route_best_path_select rbps_checker u_rbps_checker (
  .clk       (clk),
  .rst_n     (rst_n),
  .in_valid  (in_valid),
  .in_stall  (in_stall),
  .out_valid (out_valid),
  .out_stall (out_stall),
  .out_data  (out_data),
  .cfg_ready (cfg_ready)
);

/* bench/testbench.sv */
// testbench for route_best_path_select: directed and random candidate beats,
// checked against an in-bench best-path predictor; depends on rbps_pkg
`timescale 1ns / 100ps

module testbench;

  localparam int MAX_ROUTES = 256;
  localparam int DRAIN_CYCLES = 16;
  localparam int CYCLE_LIMIT = 500000;

  logic clk;
  logic rst_n = 1'b0;
  logic in_valid = 1'b0;
  logic in_stall;
  rbps_pkg::route_in_t in_data = '0;
  logic out_valid;
  logic out_stall = 1'b0;
  rbps_pkg::route_out_t out_data;
  logic cfg_valid = 1'b0;
  logic cfg_ready;
  logic [rbps_pkg::LP_W-1:0] cfg_data = '0;

  route_best_path_select DUT (
    .clk(clk),
    .rst_n(rst_n),
    .in_valid(in_valid),
    .in_stall(in_stall),
    .in_data(in_data),
    .out_valid(out_valid),
    .out_stall(out_stall),
    .out_data(out_data),
    .cfg_valid(cfg_valid),
    .cfg_ready(cfg_ready),
    .cfg_data(cfg_data)
  );

  // predictor state
  logic [rbps_pkg::LP_W-1:0] default_lp = rbps_pkg::DEFAULT_LP_RESET;
  bit held_valid;
  bit held_tunnel;
  logic [rbps_pkg::LP_W-1:0] held_pref;
  logic [rbps_pkg::HOPS_W-1:0] held_hops;
  logic [rbps_pkg::ORG_W-1:0] held_origin;
  bit held_has_med;
  logic [rbps_pkg::MED_W-1:0] held_med;
  bit held_same;
  logic [rbps_pkg::TIME_W-1:0] held_upd;
  logic [rbps_pkg::IDX_W-1:0] held_pos;
  int seen_count;
  rbps_pkg::route_out_t best_q[$];

  int mismatch_count = 0;
  int cycle_count = 0;
  int gap_pct = 0;
  int stall_pct = 0;
  int hold_len = 0;
  int hold_req = 0;
  int hold_ack = 0;
  int hold_left = 0;

  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  task automatic report_mismatch(input string what);
    $display("mismatch at cycle %0d: %s", cycle_count, what);
    mismatch_count++;
  endtask

  function automatic void clear_held();
    held_valid = 0;
    held_tunnel = 0;
    held_pref = '0;
    held_hops = '0;
    held_origin = '0;
    held_has_med = 0;
    held_med = '0;
    held_same = 0;
    held_upd = '0;
    held_pos = '0;
    seen_count = 0;
  endfunction

  function automatic bit outranks_held(input rbps_pkg::route_in_t r,
                                       input logic [rbps_pkg::LP_W-1:0] pref);
    if (!held_valid) return 1;
    if (r.via_tunnel != held_tunnel) return !r.via_tunnel;
    if (pref != held_pref) return pref > held_pref;
    if (r.as_hops != held_hops) return r.as_hops < held_hops;
    if (r.origin != held_origin) return r.origin < held_origin;
    if (r.has_med && held_has_med && r.med != held_med) return r.med < held_med;
    if (r.prefix_is_ip && r.nexthop_same_family != held_same) return r.nexthop_same_family;
    return r.updated_time > held_upd;
  endfunction

  function automatic void predict_best(input rbps_pkg::route_in_t r);
    logic [rbps_pkg::LP_W-1:0] pref;
    rbps_pkg::route_out_t res;
    pref = r.carries_lp ? r.lp_value : default_lp;
    if (seen_count < MAX_ROUTES) begin
      if (r.route_valid && outranks_held(r, pref)) begin
        held_valid = 1;
        held_tunnel = r.via_tunnel;
        held_pref = pref;
        held_hops = r.as_hops;
        held_origin = r.origin;
        held_has_med = r.has_med;
        held_med = r.med;
        held_same = r.nexthop_same_family;
        held_upd = r.updated_time;
        held_pos = seen_count[rbps_pkg::IDX_W-1:0];
      end
      seen_count++;
    end
    if (r.last) begin
      res.best_found = held_valid;
      res.best_index = held_valid ? held_pos : '0;
      best_q.push_back(res);
      clear_held();
    end
  endfunction

  // result checker and receiver stall
  always @(posedge clk) begin : result_check
    rbps_pkg::route_out_t want;
    cycle_count <= cycle_count + 1;
    if (rst_n && out_valid && !out_stall) begin
      if (best_q.size() == 0) begin
        report_mismatch("result beat with nothing expected");
      end else begin
        want = best_q.pop_front();
        if (out_data.best_found !== want.best_found)
          report_mismatch($sformatf("best_found %b, expected %b",
                                    out_data.best_found, want.best_found));
        if (out_data.best_index !== want.best_index)
          report_mismatch($sformatf("best_index %0d, expected %0d",
                                    out_data.best_index, want.best_index));
      end
    end
    if (hold_req != hold_ack) begin
      hold_ack <= hold_req;
      hold_left <= hold_len;
      out_stall <= 1'b1;
    end else if (hold_left > 0) begin
      hold_left <= hold_left - 1;
      out_stall <= 1'b1;
    end else begin
      out_stall <= ($urandom_range(99) < stall_pct);
    end
  end

  always @(posedge clk) begin
    if (cycle_count == CYCLE_LIMIT) begin
      $display("route_best_path_select regression: fail");
      $finish;
    end
  end

  task automatic send_route(input rbps_pkg::route_in_t r);
    while ($urandom_range(99) < gap_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data <= r;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    predict_best(r);
  endtask

  task automatic wait_drain();
    in_valid <= 1'b0;
    while (best_q.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  task automatic write_default(input logic [rbps_pkg::LP_W-1:0] value);
    cfg_valid <= 1'b1;
    cfg_data <= value;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    default_lp = value;
    cfg_valid <= 1'b0;
  endtask

  function automatic rbps_pkg::route_in_t cand(input bit v, tun, hlp,
                                               input logic [31:0] lp,
                                               input logic [7:0] hops,
                                               input logic [1:0] org,
                                               input bit hm, input logic [31:0] med,
                                               input bit ip, same,
                                               input logic [63:0] t,
                                               input bit last);
    rbps_pkg::route_in_t r;
    r.route_valid = v;
    r.via_tunnel = tun;
    r.carries_lp = hlp;
    r.lp_value = lp;
    r.as_hops = hops;
    r.origin = org;
    r.has_med = hm;
    r.med = med;
    r.prefix_is_ip = ip;
    r.nexthop_same_family = same;
    r.updated_time = t;
    r.last = last;
    return r;
  endfunction

  function automatic rbps_pkg::route_in_t raw_route();
    logic [159:0] raw;
    raw = {$urandom, $urandom, $urandom, $urandom, $urandom};
    return raw[$bits(rbps_pkg::route_in_t)-1:0];
  endfunction

  // values drawn from small sets so that ties push the compare chain deep
  function automatic rbps_pkg::route_in_t tie_route(input bit ip);
    rbps_pkg::route_in_t r;
    r = raw_route();
    r.route_valid = ($urandom_range(99) < 85);
    r.via_tunnel = ($urandom_range(99) < 25);
    r.carries_lp = 1'($urandom_range(1));
    case ($urandom_range(5))
      0: r.lp_value = default_lp;
      1: r.lp_value = '0;
      2: r.lp_value = 32'd100;
      3: r.lp_value = '1;
      4: r.lp_value = $urandom_range(98, 102);
      default: r.lp_value = $urandom;
    endcase
    case ($urandom_range(5))
      0: r.as_hops = 8'd0;
      1: r.as_hops = 8'd255;
      2, 3: r.as_hops = 8'($urandom_range(1, 3));
      default: r.as_hops = 8'($urandom);
    endcase
    r.origin = 2'($urandom_range(3));
    r.has_med = 1'($urandom_range(1));
    case ($urandom_range(4))
      0: r.med = '0;
      1: r.med = '1;
      2, 3: r.med = $urandom_range(1, 3);
      default: r.med = $urandom;
    endcase
    r.prefix_is_ip = ($urandom_range(9) == 0) ? 1'($urandom_range(1)) : ip;
    r.nexthop_same_family = 1'($urandom_range(1));
    case ($urandom_range(4))
      0: r.updated_time = '0;
      1: r.updated_time = '1;
      2, 3: r.updated_time = 64'($urandom_range(1, 4));
      default: r.updated_time = {$urandom, $urandom};
    endcase
    return r;
  endfunction

  task automatic send_prefixes(input int n_items, input int max_len);
    int sent;
    int len;
    bit noisy;
    bit ip;
    rbps_pkg::route_in_t r;
    sent = 0;
    while (sent < n_items) begin
      len = ($urandom_range(9) == 0) ? $urandom_range(1, 24) : $urandom_range(1, max_len);
      noisy = ($urandom_range(99) < 15);
      ip = 1'($urandom_range(1));
      for (int i = 0; i < len; i++) begin
        r = noisy ? raw_route() : tie_route(ip);
        r.last = (i == len - 1);
        send_route(r);
      end
      sent += len;
    end
  endtask

  task automatic test_reset_default();
    send_route(cand(1, 0, 1, 99, 8, 1, 0, 0, 1, 1, 1000, 0));
    send_route(cand(1, 0, 0, 0, 8, 1, 0, 0, 1, 1, 1000, 0));
    send_route(cand(1, 0, 1, 100, 8, 1, 0, 0, 1, 1, 999, 1));
    wait_drain();
  endtask

  task automatic test_no_valid_route();
    send_route(cand(0, 0, 1, '1, 0, 0, 1, 0, 1, 1, '1, 0));
    send_route(cand(0, 0, 1, '1, 0, 0, 1, 0, 1, 1, '1, 1));
    wait_drain();
  endtask

  task automatic test_each_criterion();
    // tunnel outranks everything below it: the non-tunnel route wins
    send_route(cand(1, 1, 1, '1, 0, 0, 0, 0, 1, 1, '1, 0));
    send_route(cand(1, 0, 1, 0, 255, 3, 0, 0, 1, 0, 0, 1));
    // as hops
    send_route(cand(1, 0, 1, 7, 0, 2, 0, 0, 0, 0, 5, 0));
    send_route(cand(1, 0, 1, 7, 255, 0, 0, 0, 0, 0, '1, 1));
    // origin code 3 is worst
    send_route(cand(1, 0, 1, 7, 4, 3, 0, 0, 0, 0, '1, 0));
    send_route(cand(1, 0, 1, 7, 4, 2, 0, 0, 0, 0, 0, 1));
    // med only when both carry one
    send_route(cand(1, 0, 1, 7, 4, 1, 1, '1, 0, 0, 10, 0));
    send_route(cand(1, 0, 1, 7, 4, 1, 1, 0, 0, 0, 10, 0));
    send_route(cand(1, 0, 1, 7, 4, 1, 0, 0, 0, 0, 9, 1));
    // family only for ip prefixes
    send_route(cand(1, 0, 1, 7, 4, 1, 0, 0, 1, 0, '1, 0));
    send_route(cand(1, 0, 1, 7, 4, 1, 0, 0, 1, 1, 0, 0));
    send_route(cand(1, 0, 1, 7, 4, 1, 0, 0, 0, 0, 1, 1));
    // update time, strictly later
    send_route(cand(1, 0, 1, 7, 4, 1, 0, 0, 1, 1, 7, 0));
    send_route(cand(1, 0, 1, 7, 4, 1, 0, 0, 1, 1, 7, 0));
    send_route(cand(1, 0, 1, 7, 4, 1, 0, 0, 1, 1, 8, 1));
    wait_drain();
  endtask

  task automatic test_default_mid_prefix();
    send_route(cand(1, 0, 0, 0, 4, 1, 0, 0, 1, 1, 1, 0));
    wait_drain();
    write_default(32'd50);
    send_route(cand(1, 0, 1, 75, 4, 1, 0, 0, 1, 1, 2, 1));
    wait_drain();
  endtask

  task automatic test_random_traffic(input int gap, input int stall, input int n_items,
                                     input logic [rbps_pkg::LP_W-1:0] dflt);
    wait_drain();
    write_default(dflt);
    gap_pct = gap;
    stall_pct = stall;
    send_prefixes(n_items, 6);
    wait_drain();
  endtask

  task automatic test_backpressure();
    gap_pct = 0;
    stall_pct = 0;
    hold_len <= 300;
    hold_req <= hold_req + 1;
    send_prefixes(80, 2);
    wait_drain();
  endtask

  task automatic test_sender_pause();
    gap_pct = 24;
    stall_pct = 24;
    send_prefixes(20, 4);
    wait_drain();
    send_prefixes(20, 4);
    wait_drain();
  endtask

  task automatic test_overflow();
    rbps_pkg::route_in_t r;
    gap_pct = 0;
    stall_pct = 10;
    for (int i = 0; i < 270; i++) begin
      r = tie_route(1);
      r.last = (i == 269);
      send_route(r);
    end
    // only routes past the limit are valid
    for (int i = 0; i < 258; i++) begin
      r = tie_route(0);
      r.route_valid = (i >= MAX_ROUTES);
      r.last = (i == 257);
      send_route(r);
    end
    wait_drain();
  endtask

  initial begin
    clear_held();
    repeat (9) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    test_reset_default();
    test_no_valid_route();
    test_each_criterion();
    test_default_mid_prefix();
    test_random_traffic(0, 0, 140, '0);
    test_random_traffic(86, 0, 140, '1);
    test_random_traffic(0, 86, 140, $urandom);
    test_random_traffic(24, 24, 140, 32'd100);
    test_backpressure();
    test_sender_pause();
    test_overflow();
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (best_q.size() != 0) report_mismatch("expected results never arrived");
    if (mismatch_count == 0) begin
      $display("route_best_path_select regression: pass");
    end else begin
      $display("route_best_path_select regression: fail");
    end
    $finish;
  end

endmodule
